FILE: hdl/sfdr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sfdr_pkg;

  // Byte window geometry.
  localparam int WIN_LEN   = 8;
  localparam int FRAME_LEN = 4;

  // Register reset values.
  localparam logic [7:0]  RST_RESPONSE_KEY     = 8'd0;
  localparam logic [7:0]  RST_NO_READ_CODE     = 8'd255;
  localparam logic [8:0]  RST_CONE_LIMIT       = 9'd31;
  localparam logic [7:0]  RST_ABSENT_POSITION  = 8'd0;
  localparam logic [15:0] RST_STALE_TICKS      = 16'd1000;

  localparam logic [15:0] AGE_MAX = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_RESPONSE_KEY     = 3'd0,
    CFG_NO_READ_CODE     = 3'd1,
    CFG_CONE_LIMIT       = 3'd2,
    CFG_ABSENT_POSITION  = 3'd3,
    CFG_STALE_TICKS      = 3'd4
  } cfg_idx_t;

  // Input item kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Frame event codes.
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_ALIGNED = 2'd1,
    EV_RESYNC  = 2'd2,
    EV_REJECT  = 2'd3
  } event_t;

  // Current register settings.
  typedef struct packed {
    logic [7:0]  response_key;
    logic [7:0]  no_read_code;
    logic [8:0]  cone_limit;
    logic [7:0]  absent_position;
    logic [15:0] stale_ticks;
  } cfg_t;

  // One result item.
  typedef struct packed {
    event_t      frame_event;
    logic        has_cone;
    logic        has_cube;
    logic [7:0]  cone_position;
    logic [7:0]  cube_position;
    logic        data_valid;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/sfdr_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sfdr_cfg_regs (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  output sfdr_pkg::cfg_t     cfg
);
  import sfdr_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign cfg         = cfg_r;

  // Decode the register index; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_RESPONSE_KEY:     cfg_nxt.response_key     = cfg_data[7:0];
        CFG_NO_READ_CODE:     cfg_nxt.no_read_code     = cfg_data[7:0];
        CFG_CONE_LIMIT:       cfg_nxt.cone_limit       = cfg_data[8:0];
        CFG_ABSENT_POSITION:  cfg_nxt.absent_position  = cfg_data[7:0];
        CFG_STALE_TICKS:      cfg_nxt.stale_ticks      = cfg_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.response_key     <= RST_RESPONSE_KEY;
      cfg_r.no_read_code     <= RST_NO_READ_CODE;
      cfg_r.cone_limit       <= RST_CONE_LIMIT;
      cfg_r.absent_position  <= RST_ABSENT_POSITION;
      cfg_r.stale_ticks      <= RST_STALE_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sfdr_core.sv
`timescale 1ns / 1ps
`default_nettype none

module sfdr_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic          kind,
  input  wire logic [7:0]    rx_byte,
  input  sfdr_pkg::cfg_t     cfg,
  output sfdr_pkg::res_t     res
);
  import sfdr_pkg::*;

  typedef logic [7:0] win_t [WIN_LEN];

  win_t        win_r, win_nxt, win_w;
  logic [1:0]  fill_r, fill_nxt;
  logic        cone_seen_r, cone_seen_nxt;
  logic        cube_seen_r, cube_seen_nxt;
  logic [7:0]  cone_value_r, cone_value_nxt;
  logic [7:0]  cube_value_r, cube_value_nxt;
  logic        valid_r, valid_nxt;
  logic [15:0] age_r, age_nxt;

  event_t      ev;
  logic [2:0]  wr_pos;
  logic [2:0]  take_at;
  logic        take;
  logic [3:0]  ok;
  logic [7:0]  cone_b, cube_b;
  logic        cone_hit, cube_hit;

  // Header match and 8-bit checksum of the frame starting at start.
  function automatic logic frame_ok(input win_t w, input logic [2:0] start,
                                    input logic [7:0] key);
    logic [7:0] sum;
    sum = w[start] + w[3'(start + 3'd1)] + w[3'(start + 3'd2)];
    return (w[start] == key) && (sum == w[3'(start + 3'd3)]);
  endfunction

  // Move the window left, zeros coming in at the top.
  function automatic win_t shift_win(input win_t w, input logic [2:0] by);
    win_t r;
    for (int i = 0; i < WIN_LEN; i++) begin
      if (i + int'(by) < WIN_LEN) r[i] = w[3'(i + int'(by))];
      else                        r[i] = '0;
    end
    return r;
  endfunction

  // Place the new byte and check the four candidate frames in parallel.
  assign wr_pos = {1'b1, fill_r};

  always_comb begin
    win_w = win_r;
    if (kind == KIND_BYTE) win_w[wr_pos] = rx_byte;
    for (int k = 1; k <= FRAME_LEN; k++) begin
      ok[k-1] = frame_ok(win_w, 3'(k), cfg.response_key);
    end
  end

  // Pick the frame: aligned first, then the lowest resync offset.
  always_comb begin
    take    = 1'b0;
    take_at = 3'(FRAME_LEN);
    if (ok[3]) begin
      take = 1'b1;
    end else if (ok[0]) begin
      take = 1'b1;
      take_at = 3'd1;
    end else if (ok[1]) begin
      take = 1'b1;
      take_at = 3'd2;
    end else if (ok[2]) begin
      take = 1'b1;
      take_at = 3'd3;
    end
  end

  // Object bytes of the selected frame.
  assign cone_b   = win_w[3'(take_at + 3'd1)];
  assign cube_b   = win_w[3'(take_at + 3'd2)];
  assign cone_hit = (cone_b != cfg.no_read_code) && ({1'b0, cone_b} < cfg.cone_limit);
  assign cube_hit = (cube_b != cfg.no_read_code);

  // State update for one item.
  always_comb begin
    win_nxt        = win_r;
    fill_nxt       = fill_r;
    cone_seen_nxt  = cone_seen_r;
    cube_seen_nxt  = cube_seen_r;
    cone_value_nxt = cone_value_r;
    cube_value_nxt = cube_value_r;
    valid_nxt      = valid_r;
    age_nxt        = age_r;
    ev             = EV_NONE;
    if (kind == KIND_TICK) begin
      if (age_r != AGE_MAX) age_nxt = age_r + 16'd1;
      if (age_nxt > cfg.stale_ticks) valid_nxt = 1'b0;
    end else if (fill_r != 2'd3) begin
      win_nxt  = win_w;
      fill_nxt = fill_r + 2'd1;
    end else if (take) begin
      win_nxt        = shift_win(win_w, take_at);
      fill_nxt       = 2'(3'(FRAME_LEN) - take_at);
      cone_seen_nxt  = cone_hit;
      cube_seen_nxt  = cube_hit;
      cone_value_nxt = cone_hit ? cone_b : cfg.absent_position;
      cube_value_nxt = cube_hit ? cube_b : cfg.absent_position;
      valid_nxt      = 1'b1;
      age_nxt        = '0;
      ev             = ok[3] ? EV_ALIGNED : EV_RESYNC;
    end else begin
      win_nxt  = shift_win(win_w, 3'(FRAME_LEN));
      fill_nxt = 2'd0;
      ev       = EV_REJECT;
    end
  end

  // The result shows the state after the item.
  always_comb begin
    res.frame_event   = ev;
    res.has_cone      = cone_seen_nxt;
    res.has_cube      = cube_seen_nxt;
    res.cone_position = cone_value_nxt;
    res.cube_position = cube_value_nxt;
    res.data_valid    = valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_LEN; i++) win_r[i] <= '0;
      fill_r       <= '0;
      cone_seen_r  <= 1'b0;
      cube_seen_r  <= 1'b0;
      cone_value_r <= RST_ABSENT_POSITION;
      cube_value_r <= RST_ABSENT_POSITION;
      valid_r      <= 1'b0;
      age_r        <= '0;
    end else if (step) begin
      win_r        <= win_nxt;
      fill_r       <= fill_nxt;
      cone_seen_r  <= cone_seen_nxt;
      cube_seen_r  <= cube_seen_nxt;
      cone_value_r <= cone_value_nxt;
      cube_value_r <= cube_value_nxt;
      valid_r      <= valid_nxt;
      age_r        <= age_nxt;
    end
  end

  // An accepted frame leaves fresh data behind.
  a_accept_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    step && (ev == EV_ALIGNED || ev == EV_RESYNC) |=> valid_r && (age_r == '0))
    else $error("accepted frame did not refresh valid flag and age");

  // A tick never moves the byte position.
  a_tick_keeps_fill: assert property (@(posedge clk) disable iff (!rst_n)
    step && (kind == KIND_TICK) |=> $stable(fill_r))
    else $error("tick changed the fill count");

  // A byte that does not complete a frame advances the fill count by one.
  a_byte_fills: assert property (@(posedge clk) disable iff (!rst_n)
    step && (kind == KIND_BYTE) && (fill_r != 2'd3) |=> fill_r == $past(fill_r) + 2'd1)
    else $error("partial frame byte did not advance the fill count");

  // Object data moves only on an accepted frame.
  a_objects_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(step && (ev == EV_ALIGNED || ev == EV_RESYNC))
    |=> $stable(cone_value_r) && $stable(cube_value_r))
    else $error("object positions changed without an accepted frame");

endmodule

`default_nettype wire

FILE: hdl/sensor_frame_deframer_resync_top.sv
// Path: an accepted item is held in the input register, goes through the frame logic, and its
// result is registered in the output register that drives out_tdata.
// Throughput: one item per cycle, set by the parallel frame checks between the input and
// output registers; a held output stalls the input once the input register holds an item.
// Reset: rst_n is synchronous and active low; it clears the window, flags and counters and
// loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_deframer_resync_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input item channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]  in_tuser,   // [0] kind
  // Result item channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [1:0] frame_event, [2] has_cone, [3] has_cube,
                                       // [11:4] cone_position, [19:12] cube_position,
                                       // [20] data_valid, [23:21] zero
  // Configuration write channel.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import sfdr_pkg::*;

  cfg_t        cfg;
  res_t        res;

  logic        in_valid_r, in_valid_nxt;
  logic        in_kind_r;
  logic [7:0]  in_byte_r;
  logic        out_valid_r, out_valid_nxt;
  res_t        out_res_r;
  logic        advance;
  logic        step;

  sfdr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfdr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .kind    (in_kind_r),
    .rx_byte (in_byte_r),
    .cfg     (cfg),
    .res     (res)
  );

  // The held item moves on whenever the output register is free or being emptied.
  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) in_valid_nxt = 1'b1;
    else if (step)              in_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (step)            out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_kind_r <= in_tuser[0];
      in_byte_r <= in_tdata;
    end
    if (step) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       out_res_r.data_valid,
                       out_res_r.cube_position,
                       out_res_r.cone_position,
                       out_res_r.has_cube,
                       out_res_r.has_cone,
                       out_res_r.frame_event};

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sfdr_pkg::*;

  // Configuration indexes past the register list; the block must ignore them.
  localparam logic [2:0] CFG_SPARE_LO = 3'd5;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int         MAX_REPORTS  = 100;

  // Tracks the deframer state and holds the result items still to arrive.
  class deframer_tracker;
    logic [7:0]  resp_key;
    logic [7:0]  no_read;
    logic [8:0]  cone_lim;
    logic [7:0]  dflt_pos;
    logic [15:0] stale_lim;
    logic [7:0]  win [WIN_LEN];
    logic [1:0]  fill;
    logic        cone_seen;
    logic        cube_seen;
    logic        valid_flag;
    logic [7:0]  cone_pos;
    logic [7:0]  cube_pos;
    logic [15:0] age;
    res_t        awaited [$];
    int          errors;

    function new();
      resp_key   = RST_RESPONSE_KEY;
      no_read    = RST_NO_READ_CODE;
      cone_lim   = RST_CONE_LIMIT;
      dflt_pos   = RST_ABSENT_POSITION;
      stale_lim  = RST_STALE_TICKS;
      foreach (win[i]) win[i] = '0;
      fill       = '0;
      cone_seen  = 1'b0;
      cube_seen  = 1'b0;
      valid_flag = 1'b0;
      cone_pos   = RST_ABSENT_POSITION;
      cube_pos   = RST_ABSENT_POSITION;
      age        = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        CFG_RESPONSE_KEY:     resp_key  = val[7:0];
        CFG_NO_READ_CODE:     no_read   = val[7:0];
        CFG_CONE_LIMIT:       cone_lim  = val[8:0];
        CFG_ABSENT_POSITION:  dflt_pos  = val[7:0];
        CFG_STALE_TICKS:      stale_lim = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // A frame starting at the given window offset has the right header and sum.
    function bit frame_good(int start);
      logic [7:0] sum;
      sum = win[start] + win[start + 1] + win[start + 2];
      return (win[start] == resp_key) && (sum == win[start + 3]);
    endfunction

    function void take_frame(int start);
      logic [7:0] c;
      logic [7:0] u;
      c = win[start + 1];
      u = win[start + 2];
      cone_seen  = (c != no_read) && ({1'b0, c} < cone_lim);
      cube_seen  = (u != no_read);
      cone_pos   = cone_seen ? c : dflt_pos;
      cube_pos   = cube_seen ? u : dflt_pos;
      valid_flag = 1'b1;
      age        = '0;
    endfunction

    function void slide(int by);
      for (int i = 0; i < WIN_LEN; i++) begin
        if (i + by < WIN_LEN) win[i] = win[i + by];
        else win[i] = 8'd0;
      end
    endfunction

    // Advance the state by one accepted input item and queue its result.
    function void note_item(logic kind, logic [7:0] rx);
      res_t   r;
      event_t ev;
      ev = EV_NONE;
      if (kind == KIND_TICK) begin
        if (age != AGE_MAX) age = age + 16'd1;
        if (age > stale_lim) valid_flag = 1'b0;
      end else begin
        win[FRAME_LEN + fill] = rx;
        if (fill == 2'(FRAME_LEN - 1)) begin
          if (frame_good(FRAME_LEN)) begin
            take_frame(FRAME_LEN);
            slide(FRAME_LEN);
            fill = '0;
            ev = EV_ALIGNED;
          end else begin
            // Look for a frame that straddles the old and new bytes.
            ev = EV_REJECT;
            for (int k = 1; k < FRAME_LEN && ev == EV_REJECT; k++) begin
              if (frame_good(k)) begin
                take_frame(k);
                slide(k);
                fill = 2'(FRAME_LEN - k);
                ev = EV_RESYNC;
              end
            end
            if (ev == EV_REJECT) begin
              slide(FRAME_LEN);
              fill = '0;
            end
          end
        end else begin
          fill = fill + 2'd1;
        end
      end
      r.frame_event   = ev;
      r.has_cone      = cone_seen;
      r.has_cube      = cube_seen;
      r.cone_position = cone_pos;
      r.cube_position = cube_pos;
      r.data_valid    = valid_flag;
      awaited.push_back(r);
    endfunction

    function void check_field(string fname, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
      end
    endfunction

    function void check_report(res_t got);
      res_t want;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result item, expected none, got %h", $time, got);
        return;
      end
      want = awaited.pop_front();
      check_field("frame_event", want.frame_event, got.frame_event);
      check_field("has_cone", want.has_cone, got.has_cone);
      check_field("has_cube", want.has_cube, got.has_cube);
      check_field("cone_position", want.cone_position, got.cone_position);
      check_field("cube_position", want.cube_position, got.cube_position);
      check_field("data_valid", want.data_valid, got.data_valid);
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic [0:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index  = '0;
  logic [15:0] cfg_data   = '0;

  deframer_tracker trk;
  bit              burst_mode = 1'b0;

  sensor_frame_deframer_resync_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic res_t unpack_report(logic [23:0] d);
    res_t r;
    r.frame_event   = event_t'(d[1:0]);
    r.has_cone      = d[2];
    r.has_cube      = d[3];
    r.cone_position = d[11:4];
    r.cube_position = d[19:12];
    r.data_valid    = d[20];
    return r;
  endfunction

  // Offer one item after a random gap and wait until the block takes it.
  task automatic push_item(input logic kind, input logic [7:0] b);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    trk.note_item(kind, b);
  endtask

  task automatic push_frame(input logic [7:0] h, c, u, s);
    push_item(KIND_BYTE, h);
    push_item(KIND_BYTE, c);
    push_item(KIND_BYTE, u);
    push_item(KIND_BYTE, s);
  endtask

  // Stop sending and let every outstanding result item come back.
  task automatic wait_all_reported();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (trk.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    trk.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write every register, with junk in the unused upper data bits, then a junk write to a spare index.
  task automatic apply_settings(input logic [7:0] key, nr, input logic [8:0] lim,
                                input logic [7:0] dflt, input logic [15:0] stale);
    cfg_write(CFG_RESPONSE_KEY, {8'($urandom), key});
    cfg_write(CFG_NO_READ_CODE, {8'($urandom), nr});
    cfg_write(CFG_CONE_LIMIT, {7'($urandom), lim});
    cfg_write(CFG_ABSENT_POSITION, {8'($urandom), dflt});
    cfg_write(CFG_STALE_TICKS, stale);
    cfg_write(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 16'($urandom));
  endtask

  // Object bytes lean toward the no-read code and the cone limit boundary.
  function automatic logic [7:0] object_byte();
    case ($urandom_range(0, 5))
      0: return trk.no_read;
      1: return trk.cone_lim[7:0] - 8'd1;
      2: return trk.cone_lim[7:0];
      3: return 8'($urandom_range(0, 40));
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed frames, mixed with stray bytes, bad sums and ticks.
  task automatic random_traffic(input int n_items);
    int         sent;
    int         pick;
    logic [7:0] c;
    logic [7:0] u;
    logic [7:0] s;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
      if ($urandom_range(0, 79) == 0) wait_all_reported();
      if (pick < 60) begin
        c = object_byte();
        u = object_byte();
        s = trk.resp_key + c + u;
        if ($urandom_range(0, 9) == 0) s = s ^ (8'd1 << $urandom_range(0, 7));
        push_frame(trk.resp_key, c, u, s);
        sent += 4;
      end else if (pick < 75) begin
        repeat ($urandom_range(1, 3)) begin
          push_item(KIND_BYTE, 8'($urandom));
          sent++;
        end
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4)) begin
          push_item(KIND_TICK, 8'($urandom));
          sent++;
        end
      end else begin
        push_item(KIND_BYTE, trk.resp_key);
        sent++;
      end
    end
    burst_mode = 1'b0;
  endtask

  // Result side: random stall before each item, sometimes none.
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) trk.check_report(unpack_report(out_tdata));
  end

  initial begin
    trk = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items under the reset register values.
    push_item(KIND_TICK, 8'hFF);
    push_frame(8'h00, 8'hFF, 8'hFF, 8'hFE);
    push_frame(8'h00, 8'd31, 8'd0, 8'd31);
    push_frame(8'h00, 8'd30, 8'hFF, 8'd29);
    push_frame(8'h07, 8'd1, 8'd2, 8'd3);
    // One stray byte shifts the next frame; it is found again by resync.
    push_item(KIND_BYTE, 8'd9);
    push_frame(8'h00, 8'd5, 8'd6, 8'd11);
    push_frame(8'h00, 8'd12, 8'd13, 8'd25);
    wait_all_reported();

    apply_settings(8'hA5, 8'h00, 9'd256, 8'h7F, 16'd3);
    random_traffic(180);
    wait_all_reported();

    apply_settings(8'hFF, 8'hFF, 9'd0, 8'hFF, 16'd0);
    random_traffic(170);
    wait_all_reported();

    apply_settings(8'($urandom), 8'($urandom), 9'd511, 8'($urandom),
                   16'($urandom_range(1, 40)));
    random_traffic(170);
    wait_all_reported();

    // A run of back-to-back ticks with data that never goes stale.
    apply_settings(8'h00, 8'($urandom), 9'($urandom_range(0, 300)), 8'h00, 16'hFFFF);
    push_frame(8'h00, 8'd3, 8'd4, 8'd7);
    push_frame(8'h00, 8'd3, 8'd4, 8'd7);
    burst_mode = 1'b1;
    repeat (40) push_item(KIND_TICK, 8'($urandom));
    burst_mode = 1'b0;
    wait_all_reported();
    cfg_write(CFG_STALE_TICKS, 16'hFFFE);
    push_item(KIND_TICK, 8'($urandom));
    random_traffic(170);
    wait_all_reported();

    repeat (4) @(posedge clk);
    if (trk.pending() != 0)
      $display("%0t: %0d result items never arrived", $time, trk.pending());
    if (trk.errors == 0 && trk.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("Regression FAIL");
    $finish;
  end

endmodule
